// ===== rtl/utf8_to_ucs2_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_UNIT_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define U2D_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define U2D_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define U2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/u2d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package u2d_pkg;

   localparam int CHAR_W = 16;
   localparam int COUNT_W = 16;
   localparam int ACCUM_W = 31;
   localparam int CONT_BITS = 6;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CHAR_W-1:0] REPLACEMENT_CHAR = 16'h003F;
   localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_CLEAN    = 2'd0,
      STATUS_TRUNC    = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_ZERO     = 2'd3
   } status_type;

   // One queue entry: an optional character record followed by an optional
   // end-of-string record.
   typedef struct packed {
      logic                char_valid;
      logic [CHAR_W-1:0]   char_unit;
      logic                end_valid;
      status_type          status;
      logic [COUNT_W-1:0]  count;
   } evt_type;

endpackage

// ===== rtl/u2d_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts one byte per cycle unless the queue is full, tracks the multi-byte
// form and the held-back character, and pushes each byte's records into the queue.
// ----------------------------------------------------------------------------
module u2d_front import u2d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic [COUNT_W-1:0] max_chars,
   input  logic               queue_full,
   output logic               evt_push,
   output evt_type            evt_data
);

   logic               pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0]  pend_char_ff, pend_char_in;
   logic [2:0]         remain_ff, remain_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   logic [COUNT_W-1:0] decoded_ff, decoded_in;
   logic               discard_ff, discard_in;

   logic               accept;
   logic [7:0]         in_byte;
   logic [2:0]         lead_ones;
   logic [7:0]         lead_mask;
   logic [4:0]         lead_shift;
   logic [ACCUM_W-1:0] lead_accum;
   logic [2:0]         remain_m1;
   logic [4:0]         cont_shift;
   logic [ACCUM_W-1:0] cont_accum;
   logic               is_cont;
   logic [ACCUM_W-1:0] cand_wide;
   logic [CHAR_W-1:0]  cand_char;
   logic               at_capacity;
   logic [COUNT_W-1:0] count_wo;
   logic               take_char;

   assign in_byte    = req_tdata;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Count of leading one bits, capped at seven.
   always_comb begin
      if (!in_byte[7]) begin
         lead_ones = 3'd0;
      end else if (!in_byte[6]) begin
         lead_ones = 3'd1;
      end else if (!in_byte[5]) begin
         lead_ones = 3'd2;
      end else if (!in_byte[4]) begin
         lead_ones = 3'd3;
      end else if (!in_byte[3]) begin
         lead_ones = 3'd4;
      end else if (!in_byte[2]) begin
         lead_ones = 3'd5;
      end else if (!in_byte[1]) begin
         lead_ones = 3'd6;
      end else begin
         lead_ones = 3'd7;
      end
   end

   assign lead_mask  = 8'hFF >> ({1'b0, lead_ones} + 4'd1);
   assign lead_shift = 5'(lead_ones - 3'd1) * 5'(CONT_BITS);
   assign lead_accum = ACCUM_W'(in_byte & lead_mask) << lead_shift;

   assign remain_m1  = remain_ff - 3'd1;
   assign cont_shift = 5'(remain_m1) * 5'(CONT_BITS);
   assign cont_accum = accum_ff | (ACCUM_W'(in_byte[5:0]) << cont_shift);
   assign is_cont    = (in_byte[7:6] == 2'b10);

   // Candidate character for a single byte or a completed multi-byte form.
   assign cand_wide   = (remain_ff != 3'd0) ? cont_accum : ACCUM_W'(in_byte);
   assign cand_char   = (|cand_wide[ACCUM_W-1:CHAR_W]) ? REPLACEMENT_CHAR
                                                       : cand_wide[CHAR_W-1:0];
   assign at_capacity = (decoded_ff >= max_chars);
   assign count_wo    = (pend_valid_ff && decoded_ff != '0) ? decoded_ff - 1'b1
                                                            : decoded_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      remain_in     = remain_ff;
      accum_in      = accum_ff;
      decoded_in    = decoded_ff;
      discard_in    = discard_ff;
      evt_data      = '0;
      take_char     = 1'b0;

      if (discard_ff) begin
         if (in_byte == 8'd0) begin
            discard_in = 1'b0;
         end
      end else if (remain_ff != 3'd0) begin
         if (in_byte == 8'd0) begin
            evt_data.end_valid = 1'b1;
            evt_data.status    = STATUS_TRUNC;
            evt_data.count     = count_wo;
         end else if (!is_cont) begin
            evt_data.end_valid = 1'b1;
            evt_data.status    = STATUS_TRUNC;
            evt_data.count     = count_wo;
            discard_in         = 1'b1;
         end else begin
            accum_in  = cont_accum;
            remain_in = remain_m1;
            take_char = (remain_m1 == 3'd0);
         end
      end else if (in_byte == 8'd0) begin
         // A full buffer drops the held-back character at the terminator.
         evt_data.char_valid = pend_valid_ff && !at_capacity;
         evt_data.char_unit  = pend_char_ff;
         evt_data.end_valid  = 1'b1;
         evt_data.status     = STATUS_CLEAN;
         evt_data.count      = (pend_valid_ff && at_capacity) ? count_wo : decoded_ff;
      end else if (lead_ones == 3'd0) begin
         take_char = 1'b1;
      end else if (lead_ones == 3'd1 || lead_ones == 3'd7) begin
         // Stray continuation byte or an invalid lead byte is skipped.
      end else begin
         accum_in  = lead_accum;
         remain_in = lead_ones - 3'd1;
      end

      if (take_char) begin
         if (at_capacity) begin
            evt_data.end_valid = 1'b1;
            evt_data.status    = STATUS_OVERFLOW;
            evt_data.count     = count_wo;
            discard_in         = 1'b1;
         end else if (cand_char == '0) begin
            evt_data.char_valid = pend_valid_ff;
            evt_data.char_unit  = pend_char_ff;
            evt_data.end_valid  = 1'b1;
            evt_data.status     = STATUS_ZERO;
            evt_data.count      = decoded_ff;
            discard_in          = 1'b1;
         end else begin
            evt_data.char_valid = pend_valid_ff;
            evt_data.char_unit  = pend_char_ff;
            pend_valid_in       = 1'b1;
            pend_char_in        = cand_char;
            decoded_in          = decoded_ff + 1'b1;
         end
      end

      // Every end record starts a fresh string.
      if (evt_data.end_valid) begin
         pend_valid_in = 1'b0;
         pend_char_in  = '0;
         remain_in     = 3'd0;
         accum_in      = '0;
         decoded_in    = '0;
      end
   end

   assign evt_push = accept && (evt_data.char_valid || evt_data.end_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_char_ff  <= '0;
         remain_ff     <= 3'd0;
         accum_ff      <= '0;
         decoded_ff    <= '0;
         discard_ff    <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= pend_valid_in;
         pend_char_ff  <= pend_char_in;
         remain_ff     <= remain_in;
         accum_ff      <= accum_in;
         decoded_ff    <= decoded_in;
         discard_ff    <= discard_in;
      end
   end

endmodule

// ===== rtl/u2d_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder record queue
// Small register queue that decouples the front end from the output stage.
// ----------------------------------------------------------------------------
`include "utf8_to_ucs2_decoder_unit_assert.svh"

module u2d_queue import u2d_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  evt_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output evt_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   evt_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff
                    : (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff
                    : (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `U2D_ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count out of range")
   `U2D_ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full, "push into a full queue")
   `U2D_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, head_valid, "pop from an empty queue")
   `U2D_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == CNT_W'($past(count_ff) + 1'b1), "count did not rise on push")

endmodule

// ===== rtl/u2d_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Splits queue entries into character and end records and holds each record
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module u2d_back import u2d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  evt_type            head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_code,
   output logic               rsp_is_end,
   output status_type         rsp_status,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_last
);

   logic               valid_ff, valid_in;
   logic               char_sent_ff, char_sent_in;
   logic [CHAR_W-1:0]  code_ff, code_in;
   logic               is_end_ff, is_end_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic               load;

   // The output register may take a new record when empty or being drained.
   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in     = valid_ff;
      char_sent_in = char_sent_ff;
      code_in      = code_ff;
      is_end_in    = is_end_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      pop          = 1'b0;

      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (head_data.char_valid && !char_sent_ff) begin
               code_in      = head_data.char_unit;
               is_end_in    = 1'b0;
               status_in    = STATUS_CLEAN;
               count_in     = '0;
               last_in      = !head_data.end_valid;
               char_sent_in = head_data.end_valid;
               pop          = !head_data.end_valid;
            end else begin
               code_in      = '0;
               is_end_in    = 1'b1;
               status_in    = head_data.status;
               count_in     = head_data.count;
               last_in      = 1'b1;
               char_sent_in = 1'b0;
               pop          = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         char_sent_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         char_sent_ff <= char_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff   <= code_in;
      is_end_ff <= is_end_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_code   = code_ff;
   assign rsp_is_end = is_end_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== rtl/utf8_to_ucs2_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit
// Decodes a NUL-terminated UTF-8 byte stream into 16-bit code units.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one string byte per transaction; a zero byte ends the string.
//   rsp_* carries character records (rsp_tuser low) and one end record per
//   string (rsp_tuser high) with the end status and the final character count.
//   rsp_tlast marks the last record caused by one input byte.
//   csr_* writes max_chars, the buffer capacity with the terminator included;
//   write it only while the unit is idle.
// Timing:
//   A byte is taken every cycle while the record queue is not full. Its first
//   record is written into the queue and then loaded into the output register,
//   where rsp_tvalid rises. A byte that yields a character and an end record
//   occupies the output register for both records in turn; the QUEUE_DEPTH-entry
//   record queue between the decode front end and the output stage absorbs that.
// Reset: max_chars returns to 65535 and all string state is cleared.
// Stall: when rsp_tready is low the output record holds, the queue fills, and
//   req_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit import u2d_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] in_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] code_unit, [17:16] end_status,
                                               // [33:18] char_count, [39:34] zero
   output logic                   rsp_tuser,   // [0] is_end
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_W-1:0]     csr_data
);

   logic [COUNT_W-1:0] max_chars_ff, max_chars_in;
   logic               queue_full;
   logic               evt_push;
   evt_type            evt_data;
   logic               head_valid;
   evt_type            head_data;
   logic               pop;
   logic [CHAR_W-1:0]  rsp_code;
   status_type         rsp_status;
   logic [COUNT_W-1:0] rsp_count;

   assign csr_ready    = 1'b1;
   assign max_chars_in = (csr_valid && csr_ready) ? csr_data : max_chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   u2d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .max_chars  (max_chars_ff),
      .queue_full (queue_full),
      .evt_push   (evt_push),
      .evt_data   (evt_data)
   );

   u2d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (evt_push),
      .push_data  (evt_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   u2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_code   (rsp_code),
      .rsp_is_end (rsp_tuser),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rsp_count, rsp_status, rsp_code};

endmodule

// ===== dv/tb_utf8_to_ucs2_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit testbench
// Streams NUL-terminated UTF-8 byte strings into the decoder and checks every
// output record against a cycle-independent decoder model. The run has an
// opening directed sequence, then random strings under several buffer
// capacities. Stalls and gaps are inserted on both stream sides.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder_unit;
   import u2d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int BYTES_PER_PHASE = 250;
   localparam int NUM_PHASES = 7;

   // Valid text, strays, decoded zero, truncation and bad continuation.
   localparam logic [7:0] OPENING_BYTES [24] = '{
      8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
      8'h80, 8'hFE, 8'hFF, 8'h00,
      8'hC0, 8'h80, 8'h41, 8'h00,
      8'hE2, 8'h82, 8'h00,
      8'hC3, 8'h41, 8'h00
   };
   // With a capacity of two: overflow on the third character, then full at the end.
   localparam logic [7:0] CAPACITY_BYTES [7] = '{
      8'h41, 8'h42, 8'h43, 8'h00, 8'h41, 8'h42, 8'h00
   };
   localparam logic [15:0] CAPACITY_STEPS [5] = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd65535};

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_end;
      status_type  end_status;
      logic [15:0] char_count;
      logic        is_last;
   } ucs2_record_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_W-1:0]     csr_data = '0;

   logic [7:0]      pending_bytes [$];
   ucs2_record_type expected_records [$];
   int              bytes_queued = 0;
   bit              failed = 1'b0;
   bit              no_idle = 1'b0;
   int              send_gap = 0;
   int              take_gap = 0;
   int              idle_cycles = 0;

   // Decoder model state.
   logic [15:0] capacity = 16'hFFFF;
   logic        held_valid = 1'b0;
   logic [15:0] held_char = '0;
   logic [2:0]  cont_left = '0;
   logic [30:0] accum = '0;
   logic [15:0] char_total = '0;
   logic        skipping = 1'b0;

   utf8_to_ucs2_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------- model

   function automatic void expect_char(logic [15:0] cu, logic last);
      ucs2_record_type rec;
      rec = '{code_unit: cu, is_end: 1'b0, end_status: STATUS_CLEAN, char_count: 16'd0,
              is_last: last};
      expected_records.push_back(rec);
   endfunction

   function automatic void end_string(status_type st, logic [15:0] cnt, logic keep_skipping);
      ucs2_record_type rec;
      rec = '{code_unit: 16'd0, is_end: 1'b1, end_status: st, char_count: cnt, is_last: 1'b1};
      expected_records.push_back(rec);
      held_valid = 1'b0;
      held_char = '0;
      cont_left = '0;
      accum = '0;
      char_total = '0;
      skipping = keep_skipping;
   endfunction

   // Count with the held-back character retracted.
   function automatic logic [15:0] kept_count();
      if (held_valid && char_total > 0) return char_total - 16'd1;
      return char_total;
   endfunction

   function automatic void accept_char(logic [30:0] wc);
      logic [15:0] cu;
      cu = (wc[30:16] != '0) ? REPLACEMENT_CHAR : wc[15:0];
      if (char_total >= capacity) begin
         end_string(STATUS_OVERFLOW, kept_count(), 1'b1);
         return;
      end
      if (cu == 16'd0) begin
         if (held_valid) expect_char(held_char, 1'b0);
         end_string(STATUS_ZERO, char_total, 1'b1);
         return;
      end
      if (held_valid) expect_char(held_char, 1'b1);
      held_char = cu;
      held_valid = 1'b1;
      char_total = char_total + 16'd1;
   endfunction

   function automatic void decode_utf8_byte(logic [7:0] b);
      int ones;
      int sh;
      logic [15:0] cnt;
      ones = 0;
      if (skipping) begin
         if (b == 8'h00) skipping = 1'b0;
         return;
      end
      if (cont_left != 0) begin
         if (b == 8'h00) begin
            end_string(STATUS_TRUNC, kept_count(), 1'b0);
            return;
         end
         if (b[7:6] != 2'b10) begin
            end_string(STATUS_TRUNC, kept_count(), 1'b1);
            return;
         end
         sh = (int'(cont_left) - 1) * 6;
         accum = accum | (31'(b[5:0]) << sh);
         cont_left = cont_left - 3'd1;
         if (cont_left == 0) accept_char(accum);
         return;
      end
      if (b == 8'h00) begin
         cnt = char_total;
         if (held_valid) begin
            if (char_total >= capacity) cnt = kept_count();
            else expect_char(held_char, 1'b0);
         end
         end_string(STATUS_CLEAN, cnt, 1'b0);
         return;
      end
      while (ones < 8 && b[7 - ones]) ones++;
      if (ones == 1 || ones >= 7) return;
      if (ones == 0) begin
         accept_char(31'(b));
         return;
      end
      sh = (ones - 1) * 6;
      accum = 31'(b & (8'hFF >> (ones + 1))) << sh;
      cont_left = 3'(ones - 1);
   endfunction

   // --------------------------------------------------------- request side

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) decode_utf8_byte(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_tdata <= pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------- response side

   function automatic void flag_mismatch(string field, logic [15:0] want, logic [15:0] got);
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      failed = 1'b1;
   endfunction

   function automatic void check_decoded_record();
      ucs2_record_type want;
      if (expected_records.size() == 0) begin
         $error("unexpected record: tdata 0x%0h tuser %0b tlast %0b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         failed = 1'b1;
         return;
      end
      want = expected_records.pop_front();
      if (rsp_tdata[15:0] !== want.code_unit)
         flag_mismatch("code_unit", want.code_unit, rsp_tdata[15:0]);
      if (rsp_tuser !== want.is_end)
         flag_mismatch("is_end", 16'(want.is_end), 16'(rsp_tuser));
      if (rsp_tdata[17:16] !== want.end_status)
         flag_mismatch("end_status", 16'(want.end_status), 16'(rsp_tdata[17:16]));
      if (rsp_tdata[33:18] !== want.char_count)
         flag_mismatch("char_count", want.char_count, rsp_tdata[33:18]);
      if (rsp_tlast !== want.is_last)
         flag_mismatch("is_last", 16'(want.is_last), 16'(rsp_tlast));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_decoded_record();
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            take_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------- stimulus

   function automatic void push_byte(logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void push_lead(int len);
      logic [7:0] lead_bits;
      lead_bits = 8'hFF << (8 - len);
      push_byte(lead_bits | (8'($urandom) & (8'hFF >> (len + 1))));
   endfunction

   function automatic void queue_utf8_char();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         // Overlong encoding of zero.
         len = $urandom_range(2, 3);
         push_byte(len == 2 ? 8'hC0 : 8'hE0);
         repeat (len - 1) push_byte(8'h80);
         return;
      end
      len = (r < 38) ? 1 : (r < 58) ? 2 : (r < 78) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
      if (len == 1) begin
         push_byte(8'($urandom_range(1, 127)));
      end else begin
         push_lead(len);
         repeat (len - 1) push_byte(8'h80 | 8'($urandom_range(0, 63)));
      end
   endfunction

   function automatic void queue_random_string();
      int n_chars;
      int r;
      int len;
      n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      repeat (n_chars) begin
         r = $urandom_range(0, 99);
         if (r < 2) push_byte(8'($urandom_range(8'h80, 8'hBF)));
         else if (r < 4) push_byte($urandom_range(0, 1) ? 8'hFE : 8'hFF);
         else if (r < 6) push_byte(8'($urandom_range(0, 255)));
         queue_utf8_char();
      end
      r = $urandom_range(0, 99);
      if (r < 16) begin
         len = $urandom_range(2, 6);
         push_lead(len);
         repeat ($urandom_range(0, len - 2)) push_byte(8'h80 | 8'($urandom_range(0, 63)));
         // Either the terminator arrives early or a non-continuation byte breaks in.
         if (r >= 8) begin
            push_byte($urandom_range(0, 1) ? 8'($urandom_range(1, 127))
                                           : 8'($urandom_range(8'hC0, 8'hFF)));
            repeat ($urandom_range(0, 3)) queue_utf8_char();
         end
      end
      push_byte(8'h00);
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      capacity = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      int target;
      logic [15:0] cap_value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (OPENING_BYTES[i]) push_byte(OPENING_BYTES[i]);
      wait_drained();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 5) cap_value = CAPACITY_STEPS[phase];
         else if (phase == 5) cap_value = 16'($urandom_range(3, 40));
         else cap_value = 16'($urandom_range(0, 65535));
         write_capacity(cap_value);
         no_idle = (phase == 2 || phase == 5);
         if (cap_value == 16'd2) begin
            foreach (CAPACITY_BYTES[i]) push_byte(CAPACITY_BYTES[i]);
         end
         target = bytes_queued + BYTES_PER_PHASE;
         while (bytes_queued < target) queue_random_string();
         // Sometimes leave a string open so the next capacity applies mid-string.
         if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) queue_utf8_char();
         wait_drained();
      end
      if (!failed) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
